@@ design/hex_float_add_sub_compare_macros.svh @@
// Assertion macros for the hex float add/sub/compare block.
// Used by the top level only; no other dependencies.
`ifndef HEX_FLOAT_ADD_SUB_COMPARE_MACROS_SVH
`define HEX_FLOAT_ADD_SUB_COMPARE_MACROS_SVH
`define HFA_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define HFA_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ design/hfa_pkg.sv @@
// Shared types and constants for the hex float add/sub/compare block.
// No dependencies.
package hfa_pkg;
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_CMP = 2'd2;
  localparam logic [1:0] KIND_RSV = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIG   = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_UNF   = 2'd3;
  localparam logic [1:0] CC_EQ    = 2'd0;
  localparam logic [1:0] CC_GT    = 2'd1;
  localparam logic [1:0] CC_LT    = 2'd2;
  localparam logic [63:0] CMP_ANOMALY = 64'h0000_0000_0800_0000;
  localparam int MAX_SHIFT = 14;

  typedef enum logic [1:0] {
    S_IDLE, S_ALIGN, S_NORM, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic align;
    logic norm_step;
  } cmd_t;

  typedef struct packed {
    logic align_done;
    logic norm_done;
  } sts_t;
endpackage

@@ design/hex_float_add_sub_compare.sv @@
// Sequence: load, align, then normalization that removes k leading zero hex digits (0..13).
// One transaction at a time; one normalization digit per cycle.
// The next transaction loads as the result is taken.
// Reset (synchronous, rst_n low) returns the controller to idle; no result pending.
`include "hex_float_add_sub_compare_macros.svh"
module hex_float_add_sub_compare (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_word,
  output logic [1:0]  out_status,
  output logic [1:0]  out_condition
);
  hfa_pkg::cmd_t cmd;
  hfa_pkg::sts_t sts;

  hfa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  hfa_datapath u_dp (
    .clk, .cmd, .sts,
    .kind(in_kind), .operand_a(in_operand_a), .operand_b(in_operand_b),
    .result_word(out_result_word), .status(out_status), .condition(out_condition)
  );

  `HFA_ASSERT_IMPL(a_cond_cmp, clk, rst_n, out_valid && out_condition != hfa_pkg::CC_EQ, out_status == hfa_pkg::ST_OK, "condition without clean status")
  `HFA_ASSERT_NEXT(a_load_align, clk, rst_n, cmd.load, cmd.align, "load not followed by align")
  `HFA_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "multiple commands at once")
endmodule

@@ design/hfa_datapath.sv @@
// Datapath: alignment, add/subtract, digit-serial normalization, compare.
// Depends on hfa_pkg.
module hfa_datapath (
  input  logic            clk,
  input  hfa_pkg::cmd_t   cmd,
  output hfa_pkg::sts_t   sts,
  input  logic [1:0]      kind,
  input  logic [63:0]     operand_a,
  input  logic [63:0]     operand_b,
  output logic [63:0]     result_word,
  output logic [1:0]      status,
  output logic [1:0]      condition
);
  logic [1:0]  kind_r;
  logic [63:0] a_r, b_r;
  logic        rs_r, fin_r;
  logic [8:0]  re_r, re_nxt;
  logic [63:0] rm_r, rm_nxt;
  logic        rs_nxt, fin_nxt;
  logic [1:0]  cc_r, cc_nxt;

  logic        as, bs, bse, cs;
  logic [6:0]  ae, be;
  logic [55:0] am, bm;
  logic [63:0] am4, bm4, sa, sb, sum, dif, cdif, rmx;
  logic [7:0]  dexp;
  logic [6:0]  shd;
  logic [6:0]  hi_e;
  logic        a_big, gone, eqe;

  always_comb begin
    as  = a_r[63];
    bs  = b_r[63];
    bse = (kind_r == hfa_pkg::KIND_SUB || kind_r == hfa_pkg::KIND_CMP) ? ~bs : bs;
    ae  = a_r[62:56];
    be  = b_r[62:56];
    am  = a_r[55:0];
    bm  = b_r[55:0];
    am4 = {4'd0, am, 4'd0};
    bm4 = {4'd0, bm, 4'd0};
    eqe = (ae == be);
    a_big = (ae > be);
    dexp = a_big ? ({1'b0, ae} - {1'b0, be}) : ({1'b0, be} - {1'b0, ae});
    shd  = dexp[6:0] - 7'd1;
    hi_e = a_big ? ae : be;
    sa = am4;
    sb = bm4;
    gone = 1'b0;
    if (!eqe) begin
      if (a_big) begin
        if (shd >= 7'(hfa_pkg::MAX_SHIFT)) sb = '0;
        else sb = {8'd0, bm >> {shd[3:0], 2'b00}};
        gone = (shd != 7'd0) && (sb == '0);
      end else begin
        if (shd >= 7'(hfa_pkg::MAX_SHIFT)) sa = '0;
        else sa = {8'd0, am >> {shd[3:0], 2'b00}};
        gone = (shd != 7'd0) && (sa == '0);
      end
    end
    sum  = sa + sb;
    dif  = (sa >= sb) ? sa - sb : sb - sa;
    cdif = (as != bs) ? sum : dif;
    // compare sign
    if (as != bs) cs = as;
    else if (sa >= sb) cs = as;
    else cs = ~as;

    rm_nxt = rm_r; re_nxt = re_r; rs_nxt = rs_r; fin_nxt = fin_r; cc_nxt = cc_r;
    rmx = '0;
    if (cmd.align) begin
      cc_nxt = hfa_pkg::CC_EQ;
      if (kind_r == hfa_pkg::KIND_CMP) begin
        if (am == 0 && bm == 0) cc_nxt = hfa_pkg::CC_EQ;
        else if (am == 0) cc_nxt = bs ? hfa_pkg::CC_GT : hfa_pkg::CC_LT;
        else if (bm == 0) cc_nxt = as ? hfa_pkg::CC_LT : hfa_pkg::CC_GT;
        else if (!eqe && gone)
          cc_nxt = a_big ? (as ? hfa_pkg::CC_LT : hfa_pkg::CC_GT)
                         : (bs ? hfa_pkg::CC_GT : hfa_pkg::CC_LT);
        else if (!eqe && shd >= 7'(hfa_pkg::MAX_SHIFT))
          cc_nxt = a_big ? (as ? hfa_pkg::CC_LT : hfa_pkg::CC_GT)
                         : (bs ? hfa_pkg::CC_GT : hfa_pkg::CC_LT);
        else if (cdif == hfa_pkg::CMP_ANOMALY || cdif == '0) cc_nxt = hfa_pkg::CC_EQ;
        else cc_nxt = cs ? hfa_pkg::CC_LT : hfa_pkg::CC_GT;
      end
      fin_nxt = 1'b0;
      if (am == 0 && bm == 0) begin
        rm_nxt = '0; re_nxt = '0; rs_nxt = 1'b0; fin_nxt = 1'b1;
      end else if (am == 0) begin
        rm_nxt = {8'd0, bm}; re_nxt = {2'b00, be}; rs_nxt = bse;
      end else if (bm == 0) begin
        rm_nxt = {8'd0, am}; re_nxt = {2'b00, ae}; rs_nxt = as;
      end else if (gone) begin
        rm_nxt = a_big ? {8'd0, am} : {8'd0, bm};
        re_nxt = {2'b00, hi_e}; rs_nxt = a_big ? as : bse;
        fin_nxt = 1'b1;
      end else begin
        if (as == bse) begin
          rmx = sum; rs_nxt = as;
        end else if (sa > sb) begin
          rmx = sa - sb; rs_nxt = as;
        end else begin
          rmx = sb - sa; rs_nxt = bse;
        end
        if (rmx == '0) begin
          rm_nxt = '0; re_nxt = '0; rs_nxt = 1'b0; fin_nxt = 1'b1;
        end else if (rmx[63:60] != 4'd0) begin
          rm_nxt = rmx >> 8; re_nxt = {2'b00, hi_e} + 9'd1;
        end else if (rmx[59:56] != 4'd0) begin
          rm_nxt = rmx >> 4; re_nxt = {2'b00, hi_e};
        end else begin
          rm_nxt = rmx; re_nxt = {2'b00, hi_e} - 9'd1;
        end
      end
    end else if (cmd.norm_step) begin
      rm_nxt = {rm_r[59:0], 4'd0};
      re_nxt = re_r - 9'd1;
    end
  end

  assign sts.align_done = 1'b1;
  assign sts.norm_done  = fin_r || (rm_r[55:52] != 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      a_r    <= operand_a;
      b_r    <= operand_b;
    end
    rm_r  <= rm_nxt;
    re_r  <= re_nxt;
    rs_r  <= rs_nxt;
    fin_r <= fin_nxt;
    cc_r  <= cc_nxt;
  end

  logic [1:0] st_raw;
  always_comb begin
    if (rm_r[55:0] == '0) begin
      result_word = '0; st_raw = hfa_pkg::ST_SIG;
    end else if (re_r[8]) begin
      result_word = '0; st_raw = hfa_pkg::ST_UNF;
    end else if (re_r[7]) begin
      result_word = {rs_r, re_r[6:0], rm_r[55:0]}; st_raw = hfa_pkg::ST_OVF;
    end else begin
      result_word = {rs_r, re_r[6:0], rm_r[55:0]}; st_raw = hfa_pkg::ST_OK;
    end
    status    = (kind_r == hfa_pkg::KIND_CMP) ? hfa_pkg::ST_OK : st_raw;
    condition = (kind_r == hfa_pkg::KIND_CMP) ? cc_r : hfa_pkg::CC_EQ;
  end
endmodule

@@ design/hfa_ctrl.sv @@
// Controller state machine: sequences load, align and normalization steps.
// Depends on hfa_pkg.
module hfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output hfa_pkg::cmd_t cmd,
  input  hfa_pkg::sts_t sts
);
  hfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hfa_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfa_pkg::S_IDLE:  if (in_valid) state_nxt = hfa_pkg::S_ALIGN;
      hfa_pkg::S_ALIGN: if (sts.align_done) state_nxt = hfa_pkg::S_NORM;
      hfa_pkg::S_NORM:  if (sts.norm_done) state_nxt = hfa_pkg::S_DONE;
      hfa_pkg::S_DONE:  if (!out_stall) state_nxt = in_valid ? hfa_pkg::S_ALIGN
                                                             : hfa_pkg::S_IDLE;
      default:          state_nxt = hfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      hfa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      hfa_pkg::S_ALIGN: cmd.align = 1'b1;
      hfa_pkg::S_NORM:  cmd.norm_step = !sts.norm_done;
      hfa_pkg::S_DONE: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        cmd.load  = in_valid && !out_stall;
      end
      default: ;
    endcase
  end
endmodule
